// File: rtl/clm_pkg.sv
// Shared constants and types for the component label merger.
`default_nettype none

package clm_pkg;

    localparam int LABEL_W            = 10;
    localparam int POINT_W            = 10;
    localparam int NPTS_W             = 11;
    localparam int MAX_POINTS_DEFAULT = 1024;

    localparam logic [NPTS_W-1:0]  NUM_POINTS_RESET = NPTS_W'(1024);
    localparam logic [LABEL_W-1:0] LABEL_NONE       = '0;
    localparam logic [LABEL_W-1:0] LABEL_FIRST      = LABEL_W'(1);

    typedef enum logic [8:0] {
        ST_CLEAR = 9'b000000001,
        ST_IDLE  = 9'b000000010,
        ST_RDA   = 9'b000000100,
        ST_RDB   = 9'b000001000,
        ST_DEC   = 9'b000010000,
        ST_WRB   = 9'b000100000,
        ST_MERGE = 9'b001000000,
        ST_CHECK = 9'b010000000,
        ST_OUT   = 9'b100000000
    } clm_state_t;

endpackage

`default_nettype wire

// File: rtl/component_label_merger_core.sv
// Component label merger: quick-find connectivity over a label memory.
//
// Keeps one 10-bit component label per node in a single-port-write, single-read
// memory of MAX_POINTS entries. After reset the block runs a clearing pass over
// all MAX_POINTS entries with s_ready low; configuration writes are taken meanwhile.
// For each edge, N being the active node count: two reads fetch both labels, a
// relabel sweep over nodes 0..N-1 (only when both labels are set and differ)
// reads and rewrites one entry per cycle, and a check sweep over nodes 0..N-1
// compares one label per cycle against node 0. When both nodes take a fresh
// label, a further step writes the second one, and an edge dropped for an index
// out of range skips the reads and goes straight to the check sweep. Both sweeps
// share the one memory read port. One all_connected flag is returned per edge;
// it waits in an output register, and the next edge finishes only once that
// register is free.
`default_nettype none

module component_label_merger_core
    import clm_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEFAULT
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [NPTS_W-1:0]  cfg_data,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [POINT_W-1:0] s_point_a,
    input  wire logic [POINT_W-1:0] s_point_b,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic                    m_all_connected
);

    localparam int AW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CWM = $clog2(MAX_POINTS + 1);
    localparam int CW  = (CWM > NPTS_W) ? CWM : NPTS_W;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_POINTS);
    localparam logic [CW-1:0] MAX_IDX = CW'(MAX_POINTS - 1);

    logic [LABEL_W-1:0] mem [MAX_POINTS];

    clm_state_t         state_reg, state_next;
    logic [NPTS_W-1:0]  num_points_reg;
    logic [LABEL_W-1:0] next_label_reg, next_label_next;
    logic [CW-1:0]      idx_reg, idx_next;
    logic [CW-1:0]      n_reg, n_next;
    logic [AW-1:0]      a_reg, a_next;
    logic [AW-1:0]      b_reg, b_next;
    logic [LABEL_W-1:0] la_reg, la_next;
    logic [LABEL_W-1:0] lb_reg, lb_next;
    logic [LABEL_W-1:0] first_reg, first_next;
    logic               flag_reg, flag_next;
    logic               p_vld_reg, p_vld_next;
    logic [AW-1:0]      p_addr_reg, p_addr_next;
    logic               m_valid_reg, m_valid_next;
    logic               m_data_reg, m_data_next;
    logic [LABEL_W-1:0] rdata_reg;

    logic               we;
    logic [AW-1:0]      waddr;
    logic [LABEL_W-1:0] wdata;
    logic [AW-1:0]      raddr;

    logic [CW-1:0]      np_ext, n_eff, a_ext, b_ext;
    logic [LABEL_W-1:0] label_inc;

    assign cfg_ready       = 1'b1;
    assign s_ready         = (state_reg == ST_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_all_connected = m_data_reg;

    assign np_ext    = CW'(num_points_reg);
    assign a_ext     = CW'(s_point_a);
    assign b_ext     = CW'(s_point_b);
    assign label_inc = next_label_reg + LABEL_W'(1);

    always_comb begin
        if (np_ext == '0) begin
            n_eff = CW'(1);
        end else if (np_ext > MAX_CNT) begin
            n_eff = MAX_CNT;
        end else begin
            n_eff = np_ext;
        end
    end

    // Label memory: one write and one registered read per cycle.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    always_comb begin
        state_next      = state_reg;
        next_label_next = next_label_reg;
        idx_next        = idx_reg;
        n_next          = n_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        la_next         = la_reg;
        lb_next         = lb_reg;
        first_next      = first_reg;
        flag_next       = flag_reg;
        p_vld_next      = 1'b0;
        p_addr_next     = p_addr_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;
        we              = 1'b0;
        waddr           = a_reg;
        wdata           = LABEL_NONE;
        raddr           = a_reg;

        unique case (state_reg)
            ST_CLEAR: begin
                we       = 1'b1;
                waddr    = idx_reg[AW-1:0];
                wdata    = LABEL_NONE;
                idx_next = idx_reg + CW'(1);
                if (idx_reg == MAX_IDX) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    n_next    = n_eff;
                    a_next    = a_ext[AW-1:0];
                    b_next    = b_ext[AW-1:0];
                    idx_next  = '0;
                    flag_next = 1'b1;
                    // Drop edges that touch a node outside the active range.
                    if (a_ext < n_eff && b_ext < n_eff) begin
                        state_next = ST_RDA;
                    end else begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_RDA: begin
                raddr      = a_reg;
                state_next = ST_RDB;
            end
            ST_RDB: begin
                raddr      = b_reg;
                la_next    = rdata_reg;
                state_next = ST_DEC;
            end
            ST_DEC: begin
                lb_next    = rdata_reg;
                state_next = ST_CHECK;
                if (la_reg == LABEL_NONE && rdata_reg == LABEL_NONE) begin
                    we         = 1'b1;
                    waddr      = a_reg;
                    wdata      = next_label_reg;
                    state_next = ST_WRB;
                end else if (la_reg == LABEL_NONE) begin
                    we    = 1'b1;
                    waddr = a_reg;
                    wdata = rdata_reg;
                end else if (rdata_reg == LABEL_NONE) begin
                    we    = 1'b1;
                    waddr = b_reg;
                    wdata = la_reg;
                end else if (la_reg != rdata_reg) begin
                    state_next = ST_MERGE;
                end
            end
            ST_WRB: begin
                we    = 1'b1;
                waddr = b_reg;
                wdata = next_label_reg;
                // Skip label zero on wrap.
                next_label_next = (label_inc == LABEL_NONE) ? LABEL_FIRST : label_inc;
                state_next      = ST_CHECK;
            end
            ST_MERGE: begin
                // Read node idx while rewriting the node read in the previous cycle.
                raddr       = idx_reg[AW-1:0];
                p_vld_next  = (idx_reg < n_reg);
                p_addr_next = idx_reg[AW-1:0];
                if (p_vld_reg && rdata_reg == lb_reg) begin
                    we    = 1'b1;
                    waddr = p_addr_reg;
                    wdata = la_reg;
                end
                if (idx_reg == n_reg) begin
                    idx_next   = '0;
                    state_next = ST_CHECK;
                end else begin
                    idx_next = idx_reg + CW'(1);
                end
            end
            ST_CHECK: begin
                raddr       = idx_reg[AW-1:0];
                p_vld_next  = (idx_reg < n_reg);
                p_addr_next = idx_reg[AW-1:0];
                if (p_vld_reg) begin
                    if (p_addr_reg == '0) begin
                        first_next = rdata_reg;
                    end else if (rdata_reg != first_reg) begin
                        flag_next = 1'b0;
                    end
                end
                if (idx_reg == n_reg) begin
                    state_next = ST_OUT;
                end else begin
                    idx_next = idx_reg + CW'(1);
                end
            end
            ST_OUT: begin
                // Hold until the output register is free.
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = flag_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            num_points_reg <= NUM_POINTS_RESET;
            next_label_reg <= LABEL_FIRST;
            idx_reg        <= '0;
            p_vld_reg      <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            next_label_reg <= next_label_next;
            idx_reg        <= idx_next;
            p_vld_reg      <= p_vld_next;
            m_valid_reg    <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                num_points_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        n_reg      <= n_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        la_reg     <= la_next;
        lb_reg     <= lb_next;
        first_reg  <= first_next;
        flag_reg   <= flag_next;
        p_addr_reg <= p_addr_next;
        m_data_reg <= m_data_next;
    end

    a_busy_after_transfer: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while an edge is in progress");

    a_no_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> !we)
        else $error("label memory written while idle");

    a_label_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        next_label_reg != LABEL_NONE)
        else $error("fresh label counter reached zero");

    a_merge_data: assert property (@(posedge aclk) disable iff (!aresetn)
        we && state_reg == ST_MERGE |-> wdata == la_reg && rdata_reg == lb_reg)
        else $error("relabel writes a wrong label");

endmodule

`default_nettype wire
